[design/bpet_pkg.sv]
// Shared constants, command and status types for the backprop error term unit.
// No dependencies; used by the datapath, controller and top level.
package bpet_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int ALPHA_W   = 31;
   localparam int ACC_W     = 34;
   localparam int SUM_W     = 66;
   localparam int PROD_W    = 66;
   localparam int MAGP_W    = DATA_W + ALPHA_W;
   localparam int D_W       = 64 - FRAC_BITS;
   localparam int Q_W       = ALPHA_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(Q_W);
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMOID = 1'b1;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(64'd1 << FRAC_BITS);
   localparam logic [D_W-1:0]     ONE_FX      = D_W'(64'd1 << FRAC_BITS);

   localparam logic signed [SUM_W-1:0]  ACC_MAX = SUM_W'(64'sd4294967296);
   localparam logic signed [SUM_W-1:0]  ACC_MIN = -SUM_W'(64'sd4294967296);
   localparam logic signed [PROD_W-1:0] SAT_HI  = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] SAT_LO  = -PROD_W'(64'sd2147483648);

   typedef struct packed {
      logic load;
      logic prod;
      logic accum;
      logic div_step;
      logic div_next;
      logic scale;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic last;
      logic use_sigmoid;
      logic out_free;
   } status_type;

endpackage

[design/bpet_datapath.sv]
// Datapath: item registers, multipliers, accumulator, shared divider, output register.
// Depends on bpet_pkg; driven by bpet_ctrl commands.
module bpet_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  bpet_pkg::cmd_type                 cmd,
   output bpet_pkg::status_type              status,
   input  logic                              in_action,
   input  logic                              in_last,
   input  logic signed [bpet_pkg::DATA_W-1:0] in_desired,
   input  logic signed [bpet_pkg::DATA_W-1:0] in_output,
   input  logic signed [bpet_pkg::DATA_W-1:0] in_lower,
   input  logic signed [bpet_pkg::DATA_W-1:0] in_weight,
   input  logic                              csr_we,
   input  logic [bpet_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bpet_pkg::ALPHA_W-1:0]      csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bpet_pkg::DATA_W-1:0]       rsp_tdata
);
   logic act_ff, last_ff;
   logic signed [bpet_pkg::DATA_W-1:0] des_ff, outv_ff, le_ff, w_ff;
   logic [bpet_pkg::MAGP_W-1:0] magp_ff;
   logic signed [63:0] term_ff;
   logic signed [bpet_pkg::ACC_W-1:0] acc_ff, acc_in, x_ff, x_in, acc_sat;
   logic [bpet_pkg::D_W-1:0] d_ff, rem_ff, rem_in;
   logic [bpet_pkg::Q_W-1:0] q_ff, q_in;
   logic signed [bpet_pkg::PROD_W-1:0] prod_ff;
   logic [bpet_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [bpet_pkg::ALPHA_W-1:0] alpha_ff;
   logic use_sig_ff;

   logic [bpet_pkg::DATA_W-1:0] mag;
   logic signed [bpet_pkg::SUM_W-1:0] sum;
   logic [bpet_pkg::D_W:0] rem_sh;
   logic ge;
   logic [bpet_pkg::ALPHA_W-1:0] slope;
   logic signed [bpet_pkg::DATA_W-1:0] slope_s;
   logic signed [bpet_pkg::PROD_W-1:0] sh;

   assign mag = outv_ff[bpet_pkg::DATA_W-1] ? bpet_pkg::DATA_W'(-outv_ff)
                                             : bpet_pkg::DATA_W'(outv_ff);
   assign sum = bpet_pkg::SUM_W'(acc_ff) + bpet_pkg::SUM_W'(term_ff >>> bpet_pkg::FRAC_BITS);

   always_comb begin
      if (sum > bpet_pkg::ACC_MAX) begin
         acc_sat = bpet_pkg::ACC_W'(bpet_pkg::ACC_MAX);
      end else if (sum < bpet_pkg::ACC_MIN) begin
         acc_sat = bpet_pkg::ACC_W'(bpet_pkg::ACC_MIN);
      end else begin
         acc_sat = bpet_pkg::ACC_W'(sum);
      end
      acc_in = acc_ff;
      x_in   = x_ff;
      if (cmd.accum) begin
         if (act_ff) begin
            x_in   = acc_sat;
            acc_in = last_ff ? '0 : acc_sat;
         end else begin
            x_in = bpet_pkg::ACC_W'(des_ff) - bpet_pkg::ACC_W'(outv_ff);
         end
      end
   end

   assign rem_sh = {rem_ff, q_ff[bpet_pkg::Q_W-1]};
   assign ge     = rem_sh >= {1'b0, d_ff};

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      if (cmd.accum) begin
         q_in   = {alpha_ff, bpet_pkg::FRAC_BITS'(0)};
         rem_in = '0;
      end else if (cmd.div_next) begin
         q_in   = {q_ff[bpet_pkg::ALPHA_W-1:0], bpet_pkg::FRAC_BITS'(0)};
         rem_in = '0;
      end else if (cmd.div_step) begin
         q_in   = {q_ff[bpet_pkg::Q_W-2:0], ge};
         rem_in = ge ? bpet_pkg::D_W'(rem_sh - {1'b0, d_ff}) : bpet_pkg::D_W'(rem_sh);
      end
   end

   assign slope   = use_sig_ff ? q_ff[bpet_pkg::ALPHA_W-1:0] : alpha_ff;
   assign slope_s = {1'b0, slope};
   assign sh      = prod_ff >>> bpet_pkg::FRAC_BITS;

   always_comb begin
      if (sh > bpet_pkg::SAT_HI) begin
         rsp_data_in = bpet_pkg::DATA_W'(bpet_pkg::SAT_HI);
      end else if (sh < bpet_pkg::SAT_LO) begin
         rsp_data_in = bpet_pkg::DATA_W'(bpet_pkg::SAT_LO);
      end else begin
         rsp_data_in = bpet_pkg::DATA_W'(sh);
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= in_action;
         last_ff <= in_last;
         des_ff  <= in_desired;
         outv_ff <= in_output;
         le_ff   <= in_lower;
         w_ff    <= in_weight;
      end
      if (cmd.prod) begin
         magp_ff <= bpet_pkg::MAGP_W'(mag) * bpet_pkg::MAGP_W'(alpha_ff);
         term_ff <= 64'(le_ff) * 64'(w_ff);
      end
      if (cmd.accum) begin
         d_ff <= bpet_pkg::ONE_FX
                 + bpet_pkg::D_W'(magp_ff >> bpet_pkg::FRAC_BITS);
      end
      x_ff   <= x_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (cmd.scale) begin
         prod_ff <= bpet_pkg::PROD_W'(x_ff) * bpet_pkg::PROD_W'(slope_s);
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= bpet_pkg::ALPHA_RESET;
         use_sig_ff   <= 1'b1;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               bpet_pkg::CSR_ALPHA:   alpha_ff   <= csr_wdata;
               bpet_pkg::CSR_SIGMOID: use_sig_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   assign status.action      = act_ff;
   assign status.last        = last_ff;
   assign status.use_sigmoid = use_sig_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_tdata          = rsp_data_ff;
endmodule

[design/bpet_ctrl.sv]
// Controller: product, accumulate, two restoring divisions (sigmoid), scale, emit.
// Depends on bpet_pkg; commands bpet_datapath.
module bpet_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bpet_pkg::status_type status,
   output bpet_pkg::cmd_type    cmd
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PROD  = 8'b0000_0010,
      S_ACCUM = 8'b0000_0100,
      S_DIV1  = 8'b0000_1000,
      S_REDIV = 8'b0001_0000,
      S_DIV2  = 8'b0010_0000,
      S_SCALE = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [bpet_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic cnt_done;

   assign cnt_done = cnt_ff == bpet_pkg::CNT_W'(bpet_pkg::Q_W - 1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.action && !status.last) begin
               state_in = S_IDLE;
            end else begin
               state_in = status.use_sigmoid ? S_DIV1 : S_SCALE;
            end
         end
         S_DIV1: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_done) begin
               cnt_in   = '0;
               state_in = S_REDIV;
            end
         end
         S_REDIV: begin
            cmd.div_next = 1'b1;
            state_in     = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_done) begin
               cnt_in   = '0;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
endmodule

[design/backprop_error_term_unit.sv]
// With linear slope the result is registered after the product, accumulate, scale and emit
// states; with Elliot slope two 47-step restoring divisions in one shared divider come
// before the scale, plus output backpressure. One item at a time; the next is accepted
// on return to idle. The result register lets a new item start while a result waits.
// Active-high synchronous reset: control, accumulator, output valid and CSRs to defaults.
module backprop_error_term_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,  // desired_value, output_value, lower_error, weight
   input  logic          req_tuser,  // action
   input  logic          req_tlast,  // last_term
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,  // error_value
   input  logic          csr_we,
   input  logic [bpet_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpet_pkg::ALPHA_W-1:0]   csr_wdata
);
   bpet_pkg::cmd_type    cmd;
   bpet_pkg::status_type status;

   bpet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bpet_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_action  (req_tuser),
      .in_last    (req_tlast),
      .in_desired (req_tdata[31:0]),
      .in_output  (req_tdata[63:32]),
      .in_lower   (req_tdata[95:64]),
      .in_weight  (req_tdata[127:96]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

[design/bpet_checker.sv]
// Port-level checks for backprop_error_term_unit, attached by bind.
// Depends only on the top-level ports.
module bpet_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result beat dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("result valid after reset");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("beat taken while busy");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result too early");
endmodule

bind backprop_error_term_unit bpet_checker u_bpet_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
